// ===== design/brl_pkg.sv =====
package brl_pkg;

    // Kind of an input word, carried on s_tuser
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Control bits of one queued command
    typedef struct packed {
        logic y_down;
        logic x_major;
        op_t  op;
    } brl_ctrl_t;

    localparam int CTRL_W = $bits(brl_ctrl_t);

endpackage

// ===== design/brl_front.sv =====
module brl_front #(
    parameter int COORD_BITS = 16,
    parameter int CMD_W      = 3 + 7 * 16 + 9
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  brl_pkg::op_t              in_op,
    input  logic signed [COORD_BITS-1:0] in_start_x,
    input  logic signed [COORD_BITS-1:0] in_start_y,
    input  logic signed [COORD_BITS-1:0] in_end_x,
    input  logic signed [COORD_BITS-1:0] in_end_y,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output logic [CMD_W-1:0]          cmd_data
);

    localparam int N  = COORD_BITS;
    localparam int DW = COORD_BITS + 3;

    logic                  valid_reg, valid_next;
    brl_pkg::op_t          op_reg;
    logic signed [N-1:0]   ax_reg, ay_reg, bx_reg, by_reg;
    logic [N-1:0]          dx_reg;
    logic signed [N:0]     dy_reg;

    logic                  swap;
    logic signed [N-1:0]   ax_in, ay_in, bx_in, by_in;
    logic [N:0]            dx_wide;

    logic                  y_down, x_major;
    logic [N:0]            dy_neg;
    logic [N-1:0]          ady, major, minor;
    logic signed [DW-1:0]  minor2, major1, major2, decision, inc_keep, inc_move;
    brl_pkg::brl_ctrl_t    ctrl;

    // Accept when the stage is empty or its word moves into the queue
    assign in_ready   = !valid_reg || cmd_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Order endpoints so that x rises, then y on equal x
    assign swap  = (in_start_x > in_end_x) ||
                   ((in_start_x == in_end_x) && (in_start_y > in_end_y));
    assign ax_in = swap ? in_end_x   : in_start_x;
    assign ay_in = swap ? in_end_y   : in_start_y;
    assign bx_in = swap ? in_start_x : in_end_x;
    assign by_in = swap ? in_start_y : in_end_y;
    assign dx_wide = {bx_in[N-1], bx_in} - {ax_in[N-1], ax_in};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold ordered endpoints and raw deltas
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            op_reg <= in_op;
            ax_reg <= ax_in;
            ay_reg <= ay_in;
            bx_reg <= bx_in;
            by_reg <= by_in;
            dx_reg <= dx_wide[N-1:0];
            dy_reg <= signed'({by_in[N-1], by_in} - {ay_in[N-1], ay_in});
        end
    end

    // Fix major axis, direction and decision terms
    assign y_down  = dy_reg[N];
    assign dy_neg  = (~dy_reg) + {{N{1'b0}}, 1'b1};
    assign ady     = y_down ? dy_neg[N-1:0] : dy_reg[N-1:0];
    assign x_major = dx_reg > ady;
    assign major   = x_major ? dx_reg : ady;
    assign minor   = x_major ? ady : dx_reg;
    assign minor2  = signed'({{(DW-N-1){1'b0}}, minor, 1'b0});
    assign major1  = signed'({{(DW-N){1'b0}}, major});
    assign major2  = signed'({{(DW-N-1){1'b0}}, major, 1'b0});
    assign decision = minor2 - major1;
    assign inc_keep = minor2;
    assign inc_move = minor2 - major2;

    always_comb begin
        ctrl.y_down  = y_down;
        ctrl.x_major = x_major;
        ctrl.op      = op_reg;
    end

    assign cmd_valid = valid_reg;
    assign cmd_data  = {inc_move, inc_keep, decision, by_reg, bx_reg, ay_reg, ax_reg, ctrl};

endmodule

// ===== design/brl_queue.sv =====
module brl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != 2'(DEPTH);
    assign pop_valid  = count_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming word
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/brl_back.sv =====
module brl_back #(
    parameter int COORD_BITS = 16,
    parameter int CMD_W      = 3 + 7 * 16 + 9
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  logic [CMD_W-1:0]          cmd_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COORD_BITS-1:0]     out_x,
    output logic [COORD_BITS-1:0]     out_y,
    output logic                      out_last
);

    localparam int N     = COORD_BITS;
    localparam int DW    = COORD_BITS + 3;
    localparam int AX_LO = brl_pkg::CTRL_W;
    localparam int AY_LO = AX_LO + N;
    localparam int BX_LO = AY_LO + N;
    localparam int BY_LO = BX_LO + N;
    localparam int DC_LO = BY_LO + N;
    localparam int IK_LO = DC_LO + DW;
    localparam int IM_LO = IK_LO + DW;

    brl_pkg::brl_ctrl_t    ctrl;
    logic                  take, start, emit, last;

    logic                  active_reg, active_next;
    logic                  out_valid_reg, out_valid_next;
    logic [N-1:0]          cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    logic signed [DW-1:0]  decision_reg, inc_keep_reg, inc_move_reg;
    logic                  x_major_reg, y_down_reg;
    logic [N-1:0]          out_x_reg, out_y_reg;
    logic                  out_last_reg;

    logic                  keep;
    logic [N-1:0]          y_stepped, x_stepped;

    assign ctrl      = brl_pkg::brl_ctrl_t'(cmd_data[brl_pkg::CTRL_W-1:0]);
    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign start     = take && (ctrl.op == brl_pkg::OP_START);
    assign emit      = take && (ctrl.op == brl_pkg::OP_STEP) && active_reg;
    assign last      = x_major_reg ? (cur_x_reg == stop_x_reg) : (cur_y_reg == stop_y_reg);

    assign keep      = decision_reg <= 0;
    assign x_stepped = cur_x_reg + {{(N-1){1'b0}}, 1'b1};
    assign y_stepped = y_down_reg ? cur_y_reg - {{(N-1){1'b0}}, 1'b1}
                                  : cur_y_reg + {{(N-1){1'b0}}, 1'b1};

    // Line and output control
    always_comb begin
        active_next = active_reg;
        if (start) begin
            active_next = 1'b1;
        end else if (emit && last) begin
            active_next = 1'b0;
        end
        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new line or plot, then decide
    always_ff @(posedge aclk) begin
        if (start) begin
            cur_x_reg    <= cmd_data[AX_LO +: N];
            cur_y_reg    <= cmd_data[AY_LO +: N];
            stop_x_reg   <= cmd_data[BX_LO +: N];
            stop_y_reg   <= cmd_data[BY_LO +: N];
            decision_reg <= signed'(cmd_data[DC_LO +: DW]);
            inc_keep_reg <= signed'(cmd_data[IK_LO +: DW]);
            inc_move_reg <= signed'(cmd_data[IM_LO +: DW]);
            x_major_reg  <= ctrl.x_major;
            y_down_reg   <= ctrl.y_down;
        end else if (emit && !last) begin
            decision_reg <= decision_reg + (keep ? inc_keep_reg : inc_move_reg);
            if (x_major_reg) begin
                cur_x_reg <= x_stepped;
                if (!keep) begin
                    cur_y_reg <= y_stepped;
                end
            end else begin
                cur_y_reg <= y_stepped;
                if (!keep) begin
                    cur_x_reg <= x_stepped;
                end
            end
        end
    end

    // Capture the plotted pixel
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_last_reg <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== design/bresenham_line_rasterizer.sv =====
// A step word accepted on s_ goes through the endpoint setup register, the command
// queue and the output register, in that order, before its pixel appears on m_.
// Throughput: one word per cycle unless m_tready stalls; one stepper pass per pixel.
// A start word gives no pixel; a step word while no line is active is dropped.
// Reset: aresetn low at a clock edge empties the setup stage, queue and output
// register and leaves the block with no active line.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded to bytes
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // operation
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x, pixel_y from bit 0 up, zero padded to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]  m_tdata,
    output logic                               m_tlast
);

    localparam int N       = COORD_BITS;
    localparam int DW      = COORD_BITS + 3;
    localparam int CMD_W   = brl_pkg::CTRL_W + 4 * N + 3 * DW;
    localparam int M_W     = ((2 * COORD_BITS + 7) / 8) * 8;

    logic             q_in_valid, q_in_ready;
    logic [CMD_W-1:0] q_in_data;
    logic             q_out_valid, q_out_ready;
    logic [CMD_W-1:0] q_out_data;
    logic [N-1:0]     pix_x, pix_y;

    brl_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (brl_pkg::op_t'(s_tuser[0])),
        .in_start_x (signed'(s_tdata[0 +: N])),
        .in_start_y (signed'(s_tdata[N +: N])),
        .in_end_x   (signed'(s_tdata[2*N +: N])),
        .in_end_y   (signed'(s_tdata[3*N +: N])),
        .cmd_valid  (q_in_valid),
        .cmd_ready  (q_in_ready),
        .cmd_data   (q_in_data)
    );

    brl_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    brl_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .cmd_data  (q_out_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (pix_x),
        .out_y     (pix_y),
        .out_last  (m_tlast)
    );

    assign m_tdata = M_W'({pix_y, pix_x});

endmodule
